/* hdl/esc_pkg.sv */
// ----------------------------------------------------------------------------
// esc_pkg
// Shared constants, register indexes and byte classes for the e-mail syntax
// checker and its port checker.
// ----------------------------------------------------------------------------
package esc_pkg;

  // Width of the length fields and of the configuration registers
  localparam int LEN_BITS = 10;

  // Default width of the internal byte counter
  localparam int COUNT_BITS_DEF = 10;

  // Reset values of the length bounds
  localparam logic [LEN_BITS-1:0] MIN_LEN_RST = 10'd3;
  localparam logic [LEN_BITS-1:0] MAX_LEN_RST = 10'd254;

  // Saturation value of the reported byte count
  localparam logic [LEN_BITS-1:0] OUT_COUNT_MAX = 10'd1023;

  // Shortest string that can pass every rule ("a@b.c")
  localparam logic [LEN_BITS-1:0] SHORTEST_VALID = 10'd5;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_LENGTH = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_LENGTH = 1'b1;

  // Stream payload widths
  localparam int IN_DATA_BITS  = 8;
  localparam int OUT_DATA_BITS = 16;

  // Characters of interest
  localparam logic [7:0] CHAR_AT    = 8'h40;  // '@'
  localparam logic [7:0] CHAR_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CHAR_DASH  = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_SPACE = 8'h20;  // ' '

  // Letters, digits, dot and dash are allowed in the domain part
  function automatic logic domain_byte_ok(input logic [7:0] c);
    logic ok;
    ok = (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) ||
         (c == CHAR_DOT) || (c == CHAR_DASH);
    return ok;
  endfunction

endpackage

/* hdl/email_syntax_checker.sv */
// ----------------------------------------------------------------------------
// email_syntax_checker
// Streaming syntax check of one e-mail address, one byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: s_axis_tdata carries one nonzero byte of the address,
//   s_axis_tlast marks its last byte. Bytes stream in at one per cycle
//   while no last byte is stalled. Master stream: one transaction per address,
//   issued for the last byte, carrying the verdict and the saturated length.
//   Configuration: cfg_we_i writes cfg_data_i into the register picked by
//   cfg_idx_i (0 = min_length, 1 = max_length); write only while idle.
// Pipeline:
//   A byte passes an input register and then updates the running flags;
//   the verdict lands in the output register on the same edge that the last
//   byte leaves the input register, and is offered from there. Sustained
//   rate is one byte per cycle while no last byte stalls, set by the single
//   flag-update stage between the input and output registers.
// Reset:
//   Clears both registers' valid bits, all running flags and the byte count,
//   and restores min_length = 3, max_length = 254.
// Stall:
//   While a verdict waits on the master side, non-final bytes keep flowing.
//   A last byte parks in the input register until the verdict ahead is taken,
//   and s_axis_tready drops until then.
// ----------------------------------------------------------------------------
module email_syntax_checker
  import esc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,

  // Configuration write port
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [LEN_BITS-1:0]      cfg_data_i,

  // Byte stream in
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic                     s_axis_tlast,   // final_byte

  // Verdict stream out
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata    // [0] is_valid, [10:1] byte_count,
                                                   // [15:11] zero
);

  // Compare width wide enough for both the counter and the bounds
  localparam int CMP_BITS = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam int PAD_BITS = OUT_DATA_BITS - LEN_BITS - 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [LEN_BITS-1:0] min_len_q, max_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MIN_LEN_RST;
      max_len_q <= MAX_LEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_LENGTH: min_len_q <= cfg_data_i;
        CFG_MAX_LENGTH: max_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_vld_q;
  logic       out_free;
  logic       step;

  // Output slot is free when empty or being drained this cycle
  assign out_free = !out_vld_q || m_axis_tready;
  // A non-final byte always proceeds; a final byte needs the output slot
  assign step = in_vld_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  // Payload holds while stalled
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // --------------------------------------------------------------------------
  // Running flags of the current string
  // --------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] len_q, len_d;
  logic [1:0]            at_cnt_q, at_cnt_d;
  logic                  at_first_q, at_first_d;
  logic                  sp_local_q, sp_local_d;
  logic                  bad_dom_q, bad_dom_d;
  logic                  dot_seen_q, dot_seen_d;
  logic                  dot_after_at_q, dot_after_at_d;
  logic                  prev_at_q, prev_at_d;
  logic                  in_domain;
  logic                  is_at, is_dot;
  logic                  ends_dot;

  assign is_at     = (in_byte_q == CHAR_AT);
  assign is_dot    = (in_byte_q == CHAR_DOT);
  assign in_domain = (at_cnt_q != 2'd0);

  always_comb begin
    at_cnt_d       = at_cnt_q;
    at_first_d     = at_first_q;
    sp_local_d     = sp_local_q;
    bad_dom_d      = bad_dom_q;
    dot_seen_d     = dot_seen_q;
    dot_after_at_d = dot_after_at_q;
    ends_dot       = 1'b0;

    if (is_at) begin
      // '@' as the very first byte of the string
      if (!in_domain && (len_q == '0)) at_first_d = 1'b1;
      // A second '@' spoils the domain
      if (in_domain) bad_dom_d = 1'b1;
      if (at_cnt_q != 2'd2) at_cnt_d = at_cnt_q + 2'd1;
    end else if (in_domain) begin
      if (!domain_byte_ok(in_byte_q)) bad_dom_d = 1'b1;
      if (is_dot) begin
        dot_seen_d     = 1'b1;
        dot_after_at_d = prev_at_q;
        ends_dot       = 1'b1;
      end
    end else if (in_byte_q == CHAR_SPACE) begin
      sp_local_d = 1'b1;
    end

    prev_at_d = is_at;
    len_d     = (len_q != COUNT_MAX) ? len_q + COUNT_BITS'(1) : len_q;
  end

  // Clear after the final byte so the next string starts fresh
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q          <= '0;
      at_cnt_q       <= 2'd0;
      at_first_q     <= 1'b0;
      sp_local_q     <= 1'b0;
      bad_dom_q      <= 1'b0;
      dot_seen_q     <= 1'b0;
      dot_after_at_q <= 1'b0;
      prev_at_q      <= 1'b0;
    end else if (step) begin
      if (in_last_q) begin
        len_q          <= '0;
        at_cnt_q       <= 2'd0;
        at_first_q     <= 1'b0;
        sp_local_q     <= 1'b0;
        bad_dom_q      <= 1'b0;
        dot_seen_q     <= 1'b0;
        dot_after_at_q <= 1'b0;
        prev_at_q      <= 1'b0;
      end else begin
        len_q          <= len_d;
        at_cnt_q       <= at_cnt_d;
        at_first_q     <= at_first_d;
        sp_local_q     <= sp_local_d;
        bad_dom_q      <= bad_dom_d;
        dot_seen_q     <= dot_seen_d;
        dot_after_at_q <= dot_after_at_d;
        prev_at_q      <= prev_at_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Verdict
  // --------------------------------------------------------------------------
  logic [CMP_BITS-1:0] len_ext;
  logic                len_ok;
  logic                verdict;
  logic [LEN_BITS-1:0] count_sat;

  assign len_ext = CMP_BITS'(len_d);
  assign len_ok  = (len_ext >= CMP_BITS'(min_len_q)) && (len_ext <= CMP_BITS'(max_len_q));
  assign verdict = len_ok && (at_cnt_d == 2'd1) && !at_first_d && !sp_local_d &&
                   !bad_dom_d && dot_seen_d && !dot_after_at_d && !ends_dot;
  assign count_sat = (len_ext > CMP_BITS'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX
                                                          : len_ext[LEN_BITS-1:0];

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic                is_valid_q;
  logic [LEN_BITS-1:0] byte_count_q;
  logic                load_out;

  assign load_out = step && in_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= load_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      is_valid_q   <= verdict;
      byte_count_q <= count_sat;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{PAD_BITS{1'b0}}, byte_count_q, is_valid_q};

endmodule

/* hdl/esc_checker.sv */
// ----------------------------------------------------------------------------
// esc_checker
// Port-level checks of the e-mail syntax checker, bound to its top level.
// ----------------------------------------------------------------------------
module esc_checker
  import esc_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tvalid,
  input logic                     s_axis_tready,
  input logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  input logic                     s_axis_tlast,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

  // Hold a stalled verdict steady
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("verdict changed while stalled");

  // A reported string holds at least one byte
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[LEN_BITS:1] != '0))
    else $error("zero byte count reported");

  // No passing address is shorter than five bytes ("a@b.c")
  a_valid_min_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> (m_axis_tdata[LEN_BITS:1] >= SHORTEST_VALID))
    else $error("pass verdict on too short a string");

  // No verdict appears without an earlier byte or stall on the byte stream
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready || s_axis_tvalid, 2) ||
                             $past(!s_axis_tready, 1))
    else $error("verdict without input");

endmodule

bind email_syntax_checker esc_checker u_esc_checker (.*);
